/* rtl/hnt_pkg.sv */
// Shared types, constants and the population count for the Hamming template classifier.
package hnt_pkg;

    localparam int PAT_W   = 49;
    localparam int LABEL_W = 4;
    localparam int DIST_W  = 6;
    localparam int STAT_W  = 2;
    localparam int Q_DEPTH = 2;

    localparam int PATTERN_BITS_DEF = 49;

    localparam logic KIND_QUERY    = 1'b0;
    localparam logic KIND_TEMPLATE = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_RECOGNIZED = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_REFUSED    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NO_MATCH   = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [PAT_W-1:0]   pattern;
        logic [LABEL_W-1:0] label;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [LABEL_W-1:0] digit;
        logic [DIST_W-1:0]  distance;
        logic [STAT_W-1:0]  status;
    } t_out_item;

    // One classified item on its way from front to back
    typedef struct packed {
        logic               kind;
        logic [DIST_W-1:0]  ham_dist;
        logic [LABEL_W-1:0] label;
        logic               last;
    } t_q_item;

    // Bit-sliced count of ones over 64 bits: six fixed add levels.
    function automatic logic [6:0] popcount64(input logic [63:0] v);
        logic [63:0] s1;
        logic [63:0] s2;
        logic [63:0] s3;
        logic [63:0] s4;
        logic [63:0] s5;
        logic [63:0] s6;
        s1 = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
        s3 = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        s4 = s3 + (s3 >> 8);
        s5 = s4 + (s4 >> 16);
        s6 = s5 + (s5 >> 32);
        return s6[6:0];
    endfunction

endpackage

/* rtl/hamming_nearest_template_top.sv */
// Hamming-distance nearest-template digit classifier, top level.
// One transfer is accepted every cycle while the queue has room. A query (kind 0)
// loads the reference pattern and clears the search; each template (kind 1) is
// XORed with the query and its ones counted in the accepting cycle, then queued.
// The back end updates the best distance, label and refuse flag one item per
// cycle unless a last template waits behind an unread result, and a template
// marked last loads the result register as it leaves the queue, which raises
// the result. A two-entry queue separates the ends, so input keeps flowing
// while a result waits to be taken; input stalls only once a second last template
// waits at the queue head behind an unread result and the queue behind it fills.
// P_PATTERN_BITS (1 to 49) sets how many low pattern bits take part.
module hamming_nearest_template_top import hnt_pkg::*; #(
    parameter int P_PATTERN_BITS = PATTERN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic    w_q_full;
    logic    w_q_empty;
    logic    w_q_push;
    logic    w_q_pop;
    t_q_item w_q_wr;
    t_q_item w_q_rd;

    hnt_front #(
        .P_PATTERN_BITS(P_PATTERN_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wr)
    );

    hnt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wr),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_rd)
    );

    hnt_back #(
        .P_PATTERN_BITS(P_PATTERN_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_rd),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/hnt_front.sv */
// Front end: takes input transfers, holds the query and measures each template's distance.
module hnt_front import hnt_pkg::*; #(
    parameter int P_PATTERN_BITS = PATTERN_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_q_item  o_q_data
);

    localparam logic [PAT_W-1:0] PAT_MASK = {PAT_W{1'b1}} >> (PAT_W - P_PATTERN_BITS);

    logic [PAT_W-1:0] r_query;
    logic [PAT_W-1:0] n_query;
    logic [PAT_W-1:0] w_pat;
    logic [6:0]       w_ones;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    assign w_pat  = i_in_data.pattern & PAT_MASK;
    assign w_ones = popcount64(64'(w_pat ^ r_query));

    always_comb begin
        n_query = r_query;
        if (o_q_push && i_in_data.kind == KIND_QUERY) begin
            n_query = w_pat;
        end
    end

    always_comb begin
        o_q_data.kind     = i_in_data.kind;
        o_q_data.ham_dist = w_ones[DIST_W-1:0];
        o_q_data.label    = i_in_data.label;
        o_q_data.last     = i_in_data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else begin
            r_query <= n_query;
        end
    end

endmodule

/* rtl/hnt_fifo.sv */
// Short queue of classified items between front and back.
module hnt_fifo import hnt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_q_item o_data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    t_q_item          r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

/* rtl/hnt_back.sv */
// Back end: nearest-template search state and the registered result.
module hnt_back import hnt_pkg::*; #(
    parameter int P_PATTERN_BITS = PATTERN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_q_item   i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(P_PATTERN_BITS);

    logic [DIST_W-1:0]  r_best_dist;
    logic [LABEL_W-1:0] r_best_label;
    logic               r_tie;
    logic               r_have;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [DIST_W-1:0]  n_best_dist;
    logic [LABEL_W-1:0] n_best_label;
    logic               n_tie;
    logic               n_have;
    logic               n_out_valid;
    t_out_item          n_out;
    logic               w_emit;

    // Only a last template needs the output register to be free
    assign w_emit  = !i_q_empty && i_q_data.kind == KIND_TEMPLATE && i_q_data.last;
    assign o_q_pop = !i_q_empty && (!w_emit || !r_out_valid || i_out_ready);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_best_dist  = r_best_dist;
        n_best_label = r_best_label;
        n_tie        = r_tie;
        n_have       = r_have;
        if (o_q_pop) begin
            if (i_q_data.kind == KIND_QUERY) begin
                n_best_dist  = DIST_START;
                n_best_label = '0;
                n_tie        = 1'b0;
                n_have       = 1'b0;
            end else if (i_q_data.ham_dist < r_best_dist) begin
                n_best_dist  = i_q_data.ham_dist;
                n_best_label = i_q_data.label;
                n_tie        = 1'b0;
                n_have       = 1'b1;
            end else if (i_q_data.ham_dist == r_best_dist && r_have
                         && i_q_data.label != r_best_label) begin
                n_tie = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_q_pop && w_emit) begin
            n_out_valid = 1'b1;
            if (!n_have) begin
                n_out.digit    = '0;
                n_out.distance = DIST_START;
                n_out.status   = STATUS_NO_MATCH;
            end else begin
                n_out.digit    = n_best_label;
                n_out.distance = n_best_dist;
                n_out.status   = n_tie ? STATUS_REFUSED : STATUS_RECOGNIZED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist  <= DIST_START;
            r_best_label <= '0;
            r_tie        <= 1'b0;
            r_have       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_best_dist  <= n_best_dist;
            r_best_label <= n_best_label;
            r_tie        <= n_tie;
            r_have       <= n_have;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_no_match_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> r_best_dist == DIST_START)
        else $error("best distance moved without a match");

    a_tie_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tie |-> r_have)
        else $error("refuse flag set without a match");

    a_no_match_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_NO_MATCH
        |-> o_out_data.distance == DIST_START && o_out_data.digit == '0)
        else $error("no-match result carries a label or distance");

    a_result_below_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != STATUS_NO_MATCH
        |-> o_out_data.distance < DIST_START)
        else $error("match reported at the starting distance");

endmodule
